// ===== hw/rtl/blob_orientation_from_moments_defines.svh =====
// Assertion macros for the blob orientation block.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef BLOB_ORIENTATION_FROM_MOMENTS_DEFINES_SVH
`define BLOB_ORIENTATION_FROM_MOMENTS_DEFINES_SVH

// Condition in the same cycle.
`define BOFM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition in the following cycle.
`define BOFM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bofm_pkg.sv =====
// Package for the blob orientation block: widths, constants, stage types
// and the CORDIC arctangent table. No dependencies.
package bofm_pkg;

  localparam int MOMENT_BITS   = 41;
  localparam int SPREAD_BITS   = MOMENT_BITS - 1;
  localparam int CORDIC_STAGES = 20;
  localparam int IW            = $clog2(CORDIC_STAGES);
  localparam int CW            = MOMENT_BITS + 4;
  localparam int ZW            = 33;
  localparam int TILT_BITS     = 9;

  localparam int SCALE_BITS    = 17;
  localparam int NW            = ZW + SCALE_BITS + 1;
  localparam int DEG_SHIFT     = 30;
  localparam int MW            = NW - DEG_SHIFT;
  localparam int RECIP_SHIFT   = 32;
  localparam int EW            = 2 * MW - RECIP_SHIFT;

  localparam logic signed [ZW:0]         PI_Q30    = 34'sd3373259426;
  localparam logic [SCALE_BITS-1:0]      DEG_SCALE = 17'd112500;
  localparam logic [NW-1:0]              DEG_HALF  = NW'(64'd3927 << 29);
  localparam logic [MW-1:0]              DEG_DIV   = MW'(3927);
  localparam logic [MW-1:0]              DEG_RECIP = MW'(1093701);

  localparam logic signed [TILT_BITS-1:0] TILT_ZERO     = 9'sd0;
  localparam logic signed [TILT_BITS-1:0] TILT_POS45    = 9'sd45;
  localparam logic signed [TILT_BITS-1:0] TILT_NEG45    = -9'sd45;
  localparam logic signed [TILT_BITS-1:0] TILT_NEG90    = -9'sd90;
  localparam logic signed [TILT_BITS+1:0] TILT_STRAIGHT = 11'sd180;

  localparam logic [30:0] ATAN_TAB [32] = '{
    31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159,
    31'd67021687,  31'd33543516,  31'd16775851,  31'd8388437,
    31'd4194283,   31'd2097149,   31'd1048576,   31'd524288,
    31'd262144,    31'd131072,    31'd65536,     31'd32768,
    31'd16384,     31'd8192,      31'd4096,      31'd2048,
    31'd1024,      31'd512,       31'd256,       31'd128,
    31'd64,        31'd32,        31'd16,        31'd8,
    31'd4,         31'd2,         31'd1,         31'd0
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } bofm_vec_t;

  typedef struct packed {
    logic                        fixed;
    logic signed [TILT_BITS-1:0] fixed_val;
    logic                        m_neg;
    logic                        d_neg;
  } bofm_side_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [IW-1:0] idx);
    return ZW'(ATAN_TAB[idx]);
  endfunction

endpackage

// ===== hw/rtl/bofm_prep.sv =====
// Input stage: magnitudes, signs and special cases of one moment word.
// Depends on bofm_pkg.
module bofm_prep (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic signed [bofm_pkg::MOMENT_BITS-1:0] cross_moment_i,
  input  logic [bofm_pkg::SPREAD_BITS-1:0]       x_spread_i,
  input  logic [bofm_pkg::SPREAD_BITS-1:0]       y_spread_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output bofm_pkg::bofm_vec_t                    vec_o,
  output bofm_pkg::bofm_side_t                   side_o
);
  import bofm_pkg::*;

  logic                   valid_q;
  logic [MOMENT_BITS-1:0] mag;
  logic [SPREAD_BITS-1:0] diff;
  logic                   m_neg;
  logic                   d_neg;
  bofm_vec_t              vec_d, vec_q;
  bofm_side_t             side_d, side_q;

  always_comb begin
    m_neg = cross_moment_i[MOMENT_BITS-1];
    mag   = m_neg ? MOMENT_BITS'(-cross_moment_i) : MOMENT_BITS'(cross_moment_i);
    d_neg = y_spread_i > x_spread_i;
    diff  = d_neg ? (y_spread_i - x_spread_i) : (x_spread_i - y_spread_i);

    vec_d.x = CW'(diff);
    vec_d.y = CW'({mag, 1'b0});
    vec_d.z = '0;

    side_d.m_neg = m_neg;
    side_d.d_neg = d_neg;
    side_d.fixed = (diff == '0) || (mag == '0);
    priority if (diff == '0) begin
      if (mag == '0) begin
        side_d.fixed_val = TILT_ZERO;
      end else if (m_neg) begin
        side_d.fixed_val = TILT_NEG45;
      end else begin
        side_d.fixed_val = TILT_POS45;
      end
    end else if (d_neg) begin
      side_d.fixed_val = TILT_NEG90;
    end else begin
      side_d.fixed_val = TILT_ZERO;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      vec_q  <= vec_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;
  assign side_o  = side_q;

endmodule

// ===== hw/rtl/bofm_cell.sv =====
// One vectoring CORDIC iteration with its pipeline register.
// Depends on bofm_pkg for the vector types and the arctangent table.
module bofm_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [bofm_pkg::IW-1:0] stage_i,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  bofm_pkg::bofm_vec_t     vec_i,
  input  bofm_pkg::bofm_side_t    side_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output bofm_pkg::bofm_vec_t     vec_o,
  output bofm_pkg::bofm_side_t    side_o
);
  import bofm_pkg::*;

  logic                 valid_q;
  logic signed [CW-1:0] x_in, y_in, dx, dy;
  logic signed [ZW-1:0] z_in, ang;
  bofm_vec_t            vec_d, vec_q;
  bofm_side_t           side_q;

  always_comb begin
    x_in = vec_i.x;
    y_in = vec_i.y;
    z_in = vec_i.z;
    dx   = y_in >>> stage_i;
    dy   = x_in >>> stage_i;
    ang  = atan_q30(stage_i);
    if (y_in > 0) begin
      vec_d.x = x_in + dx;
      vec_d.y = y_in - dy;
      vec_d.z = z_in + ang;
    end else begin
      vec_d.x = x_in - dx;
      vec_d.y = y_in + dy;
      vec_d.z = z_in - ang;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      vec_q  <= vec_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;
  assign side_o  = side_q;

endmodule

// ===== hw/rtl/bofm_deg.sv =====
// Converts the CORDIC angle to whole degrees and applies the quadrant map.
// Three registered steps; depends on bofm_pkg.
module bofm_deg (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  bofm_pkg::bofm_vec_t                   vec_i,
  input  bofm_pkg::bofm_side_t                  side_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic signed [bofm_pkg::TILT_BITS-1:0] tilt_o
);
  import bofm_pkg::*;

  logic                        va_q, vb_q, vc_q;
  logic                        ready_a, ready_b, ready_c;
  logic signed [ZW:0]          q_ang;
  logic [ZW-1:0]               u_ang;
  logic [NW-1:0]               num;
  logic [MW-1:0]               ma_q, mb_q;
  bofm_side_t                  sa_q, sb_q;
  logic [2*MW-1:0]             prod;
  logic [EW-1:0]               eb_q;
  logic [MW-1:0]               rem;
  logic [EW-1:0]               base;
  logic signed [TILT_BITS+1:0] tilt_wide;
  logic signed [TILT_BITS-1:0] tilt_d, tilt_q;

  always_comb begin
    q_ang = side_i.d_neg ? (PI_Q30 - (ZW+1)'(vec_i.z)) : (ZW+1)'(vec_i.z);
    u_ang = (q_ang > 0) ? q_ang[ZW-1:0] : '0;
    num   = NW'(u_ang * DEG_SCALE) + DEG_HALF;
  end

  assign prod = ma_q * DEG_RECIP;

  always_comb begin
    rem  = mb_q - MW'(eb_q * DEG_DIV);
    base = (rem >= DEG_DIV) ? eb_q + EW'(1) : eb_q;
    if (sb_q.m_neg) begin
      tilt_wide = TILT_STRAIGHT - (TILT_BITS+2)'(base);
    end else begin
      tilt_wide = (TILT_BITS+2)'(base);
    end
    tilt_d = sb_q.fixed ? sb_q.fixed_val : tilt_wide[TILT_BITS-1:0];
  end

  assign ready_c = !vc_q || ready_i;
  assign ready_b = !vb_q || ready_c;
  assign ready_a = !va_q || ready_b;
  assign ready_o = ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (ready_a) begin
        va_q <= valid_i;
      end
      if (ready_b) begin
        vb_q <= va_q;
      end
      if (ready_c) begin
        vc_q <= vb_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i) begin
      ma_q <= num[NW-1:DEG_SHIFT];
      sa_q <= side_i;
    end
    if (ready_b && va_q) begin
      mb_q <= ma_q;
      eb_q <= prod[2*MW-1:RECIP_SHIFT];
      sb_q <= sa_q;
    end
    if (ready_c && vb_q) begin
      tilt_q <= tilt_d;
    end
  end

  assign valid_o = vc_q;
  assign tilt_o  = tilt_q;

endmodule

// ===== hw/rtl/blob_orientation_from_moments.sv =====
// Blob orientation from second-order central moments: top level.
// Holds the input stage, the row of CORDIC cells and the degree stage.
// Depends on bofm_pkg, bofm_prep, bofm_cell, bofm_deg and the defines header.
//
// One input word carries mu11 (cross_moment_i), mu20 (x_spread_i) and
// mu02 (y_spread_i); one output word carries the axis angle in whole
// degrees (tilt_degrees_o, -90 to 180). Every input word gives exactly one
// output word, in order. Both channels hand over a word at a clock edge
// where valid is high and stall is low.
// The pipeline has one input stage, 20 CORDIC cells and three registered
// steps for the degree conversion. One word enters per cycle unless an output
// stall holds it; the row of cells, one iteration per cell, sets that rate.
// Every stage keeps its own valid bit, so bubbles close up while the
// receiver stalls and new words are taken until the pipeline is full.
// in_stall_o is high only when every stage holds a word and out_stall_i
// is high. Reset clears all valid bits; nothing else needs clearing.
`include "blob_orientation_from_moments_defines.svh"

module blob_orientation_from_moments (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [bofm_pkg::MOMENT_BITS-1:0] cross_moment_i,
  input  logic [bofm_pkg::SPREAD_BITS-1:0]       x_spread_i,
  input  logic [bofm_pkg::SPREAD_BITS-1:0]       y_spread_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [bofm_pkg::TILT_BITS-1:0]  tilt_degrees_o
);
  import bofm_pkg::*;

  logic       prep_ready;
  logic       deg_ready;
  logic       valid   [CORDIC_STAGES+1];
  logic       ready   [CORDIC_STAGES+1];
  bofm_vec_t  vec     [CORDIC_STAGES+1];
  bofm_side_t side    [CORDIC_STAGES+1];

  bofm_prep u_prep (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_valid_i),
    .ready_o        (prep_ready),
    .cross_moment_i (cross_moment_i),
    .x_spread_i     (x_spread_i),
    .y_spread_i     (y_spread_i),
    .valid_o        (valid[0]),
    .ready_i        (ready[0]),
    .vec_o          (vec[0]),
    .side_o         (side[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    bofm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (IW'(k)),
      .valid_i (valid[k]),
      .ready_o (ready[k]),
      .vec_i   (vec[k]),
      .side_i  (side[k]),
      .valid_o (valid[k+1]),
      .ready_i (ready[k+1]),
      .vec_o   (vec[k+1]),
      .side_o  (side[k+1])
    );
  end

  assign ready[CORDIC_STAGES] = deg_ready;

  bofm_deg u_deg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid[CORDIC_STAGES]),
    .ready_o (deg_ready),
    .vec_i   (vec[CORDIC_STAGES]),
    .side_i  (side[CORDIC_STAGES]),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .tilt_o  (tilt_degrees_o)
  );

  assign in_stall_o = !prep_ready;

  `BOFM_ASSERT_SAME(a_tilt_range, out_valid_o, (tilt_degrees_o >= TILT_NEG90) && (tilt_degrees_o <= 9'sd180), "Output word outside -90 to 180 degrees.")
  `BOFM_ASSERT_SAME(a_no_false_stall, !out_stall_i, !in_stall_o, "Input stalled although the receiver takes words.")
  `BOFM_ASSERT_NEXT(a_fill_stall, out_valid_o && out_stall_i && in_stall_o, in_stall_o || !out_stall_i, "Full pipeline released without a word leaving.")

endmodule

// ===== tb/tb.sv =====
// Testbench for blob_orientation_from_moments: drives moment sets through
// valid/stall handshakes and checks each tilt against an in-bench predictor.
// Depends only on the RTL and its package bofm_pkg.
`timescale 1ns / 100ps

module tb;

  localparam int MB     = bofm_pkg::MOMENT_BITS;
  localparam int SB     = bofm_pkg::SPREAD_BITS;
  localparam int TB     = bofm_pkg::TILT_BITS;
  localparam int STAGES = bofm_pkg::CORDIC_STAGES;

  localparam longint PI_Q30_RAD = 64'sd3373259426;
  localparam longint ARCTAN_Q30 [32] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128,
    64, 32, 16, 8, 4, 2,
    1, 0
  };

  localparam logic signed [MB-1:0] CROSS_MAX = {1'b0, {(MB-1){1'b1}}};
  localparam logic signed [MB-1:0] CROSS_MIN = {1'b1, {(MB-1){1'b0}}};
  localparam logic [SB-1:0]        SPREAD_MAX = '1;

  typedef struct {
    logic signed [MB-1:0] mu11;
    logic [SB-1:0]        mu20;
    logic [SB-1:0]        mu02;
    logic signed [TB-1:0] tilt;
  } tilt_expect_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic signed [MB-1:0] cross_moment_i = '0;
  logic [SB-1:0]        x_spread_i = '0;
  logic [SB-1:0]        y_spread_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [TB-1:0] tilt_degrees_o;

  tilt_expect_t pending_tilts[$];
  int           mismatches = 0;
  int           words_sent = 0;
  int           tilts_checked = 0;
  int           send_idle_pct = 30;
  int           recv_idle_pct = 30;

  blob_orientation_from_moments DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cross_moment_i(cross_moment_i),
    .x_spread_i    (x_spread_i),
    .y_spread_i    (y_spread_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .tilt_degrees_o(tilt_degrees_o)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #(20_000_000);
    $display("Timeout with %0d tilts still outstanding.", pending_tilts.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic signed [TB-1:0] predict_tilt(input logic signed [MB-1:0] mu11,
                                                        input logic [SB-1:0] mu20,
                                                        input logic [SB-1:0] mu02);
    longint      m, x, y, z, dx, dy, q, base, tilt;
    logic [63:0] a, b, u;
    bit          m_neg, d_neg;
    int unsigned sh;
    m = mu11;
    m_neg = (m < 0);
    a = m_neg ? -m : m;
    d_neg = (mu02 > mu20);
    b = d_neg ? 64'(mu02) - 64'(mu20) : 64'(mu20) - 64'(mu02);
    if (b == 0) begin
      tilt = (a == 0) ? 0 : (m_neg ? -45 : 45);
    end else if (a == 0) begin
      tilt = d_neg ? -90 : 0;
    end else begin
      sh = 0;
      while (((a >> sh) >= (64'd1 << 41)) || ((b >> sh) >= (64'd1 << 42))) sh++;
      y = (sh == 0) ? $signed(a << 1) : $signed(a >> (sh - 1));
      x = $signed(b >> sh);
      z = 0;
      for (int i = 0; i < STAGES && i < 32; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx;
          y -= dy;
          z += ARCTAN_Q30[i];
        end else begin
          x -= dx;
          y += dy;
          z -= ARCTAN_Q30[i];
        end
      end
      q = d_neg ? PI_Q30_RAD - z : z;
      u = (q > 0) ? 64'(q) : 64'd0;
      base = $signed((u * 64'd112500 + (64'd3927 << 29)) / (64'd3927 << 30));
      tilt = m_neg ? 180 - base : base;
    end
    return tilt[TB-1:0];
  endfunction

  function automatic logic [63:0] rand_bits(input int unsigned n);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (n >= 64) return v;
    return v & ((64'd1 << n) - 64'd1);
  endfunction

  function automatic int draw_wait(input int pct);
    if ($urandom_range(0, 99) < pct) return $urandom_range(0, 17);
    return 0;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic send_word(input logic signed [MB-1:0] mu11, input logic [SB-1:0] mu20,
                           input logic [SB-1:0] mu02);
    int           gap;
    tilt_expect_t e;
    gap = draw_wait(send_idle_pct);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cross_moment_i <= mu11;
    x_spread_i     <= mu20;
    y_spread_i     <= mu02;
    do @(posedge clk_i); while (in_stall_o);
    e.mu11 = mu11;
    e.mu20 = mu20;
    e.mu02 = mu02;
    e.tilt = predict_tilt(mu11, mu20, mu02);
    pending_tilts = {pending_tilts, e};
    words_sent++;
  endtask

  task automatic send_random_word();
    logic signed [MB-1:0] c;
    logic [SB-1:0]        x, y;
    logic [63:0]          mag;
    case ($urandom_range(0, 9))
      0: c = '0;
      1: c = MB'({$urandom, $urandom});
      default: begin
        mag = rand_bits($urandom_range(0, SB));
        c = $urandom_range(0, 1) ? -MB'(mag) : MB'(mag);
      end
    endcase
    x = SB'(rand_bits($urandom_range(0, SB)));
    case ($urandom_range(0, 7))
      0: y = x;
      1: y = x ^ SB'(rand_bits($urandom_range(0, 8)));
      default: y = SB'(rand_bits($urandom_range(0, SB)));
    endcase
    send_word(c, x, y);
  endtask

  always @(posedge clk_i) begin
    tilt_expect_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_tilts.size() == 0) begin
        report_mismatch($sformatf("tilt %0d arrived with no word outstanding", tilt_degrees_o));
      end else begin
        e = pending_tilts.pop_front();
        tilts_checked++;
        if (tilt_degrees_o !== e.tilt) begin
          report_mismatch($sformatf("mu11=%0d mu20=%0d mu02=%0d: tilt %0d, predicted %0d",
                                    e.mu11, e.mu20, e.mu02, tilt_degrees_o, e.tilt));
        end
      end
    end
  end

  initial begin
    int n;
    @(posedge clk_i);
    forever begin
      n = draw_wait(recv_idle_pct);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic test_corner_cases();
    send_idle_pct = 40;
    recv_idle_pct = 40;
    send_word('0, '0, '0);
    send_word(5, 7, 7);
    send_word(-5, 7, 7);
    send_word('0, 10, 3);
    send_word('0, 3, 10);
    send_word(1, 2, 1);
    send_word(-1, 2, 1);
    send_word(1, 1, 2);
    send_word(-1, 1, 2);
    send_word(CROSS_MAX, '0, '0);
    send_word(CROSS_MIN, SPREAD_MAX, SPREAD_MAX);
    send_word(CROSS_MAX, SPREAD_MAX, '0);
    send_word(CROSS_MIN, SPREAD_MAX, '0);
    send_word(CROSS_MAX, '0, SPREAD_MAX);
    send_word(CROSS_MIN, '0, SPREAD_MAX);
    send_word(1, SPREAD_MAX, '0);
    send_word(-1, SPREAD_MAX, '0);
    send_word(1, '0, SPREAD_MAX);
    send_word(-1, '0, SPREAD_MAX);
    send_word(CROSS_MAX, 1, '0);
    send_word(CROSS_MIN, '0, 1);
    send_word('0, SPREAD_MAX, '0);
    send_word('0, '0, SPREAD_MAX);
    send_word(MB'(41'sh0AAAAAAAAAA), 40'h5555555555, 40'hAAAAAAAAAA);
    send_word(MB'(41'sh15555555555), 40'hAAAAAAAAAA, 40'h5555555555);
  endtask

  task automatic test_random_moments();
    send_idle_pct = 35;
    recv_idle_pct = 35;
    repeat (1100) send_random_word();
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (250) send_random_word();
  endtask

  task automatic test_receiver_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 90;
    repeat (250) send_random_word();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_cases();
    test_random_moments();
    test_full_rate();
    test_receiver_backpressure();
    in_valid_i <= 1'b0;
    while (pending_tilts.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Sent %0d moment sets and checked %0d tilts: corner moments, random signs",
             words_sent, tilts_checked);
    $display("and magnitudes, full-rate streams and heavy output stalls; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== blob_orientation_from_moments.f =====
+incdir+hw/rtl
hw/rtl/bofm_pkg.sv
hw/rtl/bofm_prep.sv
hw/rtl/bofm_cell.sv
hw/rtl/bofm_deg.sv
hw/rtl/blob_orientation_from_moments.sv
tb/tb.sv
